// ----- hw/rtl/sspd_pkg.sv -----
// Shared constants and codes for the stereo playback speed and delay unit.
package sspd_pkg;

  // Largest ring length in frames, used as the default depth of the delay memory.
  localparam int MAX_DELAY_FRAMES_DEF = 65536;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int MODE_W   = 2;
  localparam int DELAY_W  = 17;
  localparam int CFG_IDX_W = 1;

  // Reset value of the delay length register.
  localparam logic [DELAY_W-1:0] DELAY_FRAMES_RST = 17'd44100;

  // Playback modes held in the mode register.
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HALF   = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_DELAY  = 2'd3
  } mode_t;

  // Request kinds carried on the input tuser.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'b1;

endpackage

// ----- hw/rtl/sspd_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module sspd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/stereo_playback_speed_and_delay_unit.sv -----
// Top level of the stereo playback speed and delay unit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | slave     | in_tvalid / in_tready | tdata: left, right; tuser: opcode
//   out     | master    | out_tvalid/out_tready | tdata: left, right; tlast; tuser: done
//   cfg     | slave     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// An accepted request passes through the stage register and then the output register.
// Normal, double speed, delay and drain sustain one request per cycle while the output is
// not stalled; half speed takes the next request only as the second of its two output beats leaves.
// The delay memory is read and written at the acceptance edge (read-first), so
// back-to-back requests to the same entry need no interlock.
// After reset a clearing pass zeroes all MAX_DELAY_FRAMES entries (65536 by default)
// of the delay memory, during which no request is accepted; configuration writes
// are taken throughout. A stalled output holds one result and one in the stage behind.
module stereo_playback_speed_and_delay_unit #(
  parameter int MAX_DELAY_FRAMES = sspd_pkg::MAX_DELAY_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic                           in_tuser,   // [0] opcode
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [15:0] left_out, [31:16] right_out
  output logic                           out_tlast,
  output logic                           out_tuser,  // [0] drain_done
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [sspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sspd_pkg::DELAY_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_DELAY_FRAMES);
  localparam int LW = $clog2(MAX_DELAY_FRAMES + 1);
  localparam int CW = (LW > sspd_pkg::DELAY_W) ? LW : sspd_pkg::DELAY_W;
  localparam int SW = sspd_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  clr_addr_r, clr_addr_nxt;

  sspd_pkg::mode_t                mode_r;
  logic [sspd_pkg::DELAY_W-1:0]   delay_frames_r;

  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic                           parity_r, parity_nxt;
  logic [LW-1:0]                  drain_cnt_r, drain_cnt_nxt;

  // Stage between acceptance and the output register.
  logic                           s1_v_r;
  logic                           s1_two_r;
  logic                           s1_ram_r;
  logic                           s1_done_r;
  logic signed [SW-1:0]           s1_left_r;
  logic signed [SW-1:0]           s1_right_r;

  // Output register.
  logic                           out_v_r;
  logic signed [SW-1:0]           out_left_r;
  logic signed [SW-1:0]           out_right_r;
  logic                           out_last_r;
  logic                           out_done_r;

  logic                           accept;
  logic                           is_drain;
  logic                           out_free;
  logic                           s1_emit;
  logic                           s1_leave;
  logic                           acc_load;
  logic                           acc_two;
  logic                           acc_ram;
  logic                           acc_done;
  logic                           acc_wr;
  logic signed [SW-1:0]           acc_wdata;
  logic signed [SW-1:0]           acc_right;
  logic signed [SW-1:0]           in_left;
  logic signed [SW-1:0]           in_right;

  logic [CW-1:0]                  len_wide;
  logic [LW-1:0]                  ring_len;
  logic [AW:0]                    ptr_inc;
  logic [AW-1:0]                  ptr_adv;
  logic [LW-1:0]                  cnt_inc;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [SW-1:0]                  ram_wdata;
  logic [SW-1:0]                  ram_rdata;

  assign in_left  = in_tdata[SW-1:0];
  assign in_right = in_tdata[2*SW-1:SW];

  // Ring length: zero counts as one, and the memory depth caps it.
  always_comb begin
    len_wide = CW'(delay_frames_r);
    if (len_wide == '0) begin
      len_wide = CW'(1);
    end
    if (len_wide > CW'(MAX_DELAY_FRAMES)) begin
      len_wide = CW'(MAX_DELAY_FRAMES);
    end
  end
  assign ring_len = len_wide[LW-1:0];

  // Pointer advance with wrap, also wrapping a pointer left beyond a shorter ring.
  assign ptr_inc = {1'b0, ptr_r} + (AW+1)'(1);
  assign ptr_adv = (ptr_inc >= (AW+1)'(ring_len)) ? '0 : ptr_inc[AW-1:0];
  assign cnt_inc = drain_cnt_r + LW'(1);

  // Handshake: a slot frees when the stage ahead hands its last beat on.
  assign out_free  = !out_v_r || out_tready;
  assign s1_emit   = s1_v_r && out_free;
  assign s1_leave  = s1_emit && !s1_two_r;
  assign in_tready = (state_r == ST_RUN) && (!s1_v_r || s1_leave);
  assign accept    = in_tvalid && in_tready;
  assign is_drain  = (in_tuser == sspd_pkg::OP_DRAIN);

  // Decode of an accepted request into stage contents and state updates.
  always_comb begin
    acc_load      = 1'b1;
    acc_two       = 1'b0;
    acc_ram       = 1'b0;
    acc_done      = 1'b0;
    acc_wr        = 1'b0;
    acc_wdata     = in_left;
    acc_right     = in_right;
    ptr_nxt       = ptr_r;
    parity_nxt    = parity_r;
    drain_cnt_nxt = drain_cnt_r;
    if (accept) begin
      if (is_drain) begin
        acc_ram   = 1'b1;
        acc_right = '0;
        acc_wr    = 1'b1;
        acc_wdata = '0;
        ptr_nxt   = ptr_adv;
        if (cnt_inc >= ring_len) begin
          acc_done      = 1'b1;
          drain_cnt_nxt = '0;
        end else begin
          drain_cnt_nxt = cnt_inc;
        end
      end else begin
        drain_cnt_nxt = '0;
        case (mode_r)
          sspd_pkg::MODE_NORMAL: begin
            acc_load = 1'b1;
          end
          sspd_pkg::MODE_HALF: begin
            acc_two = 1'b1;
          end
          sspd_pkg::MODE_DOUBLE: begin
            acc_load   = !parity_r;
            parity_nxt = !parity_r;
          end
          sspd_pkg::MODE_DELAY: begin
            acc_ram = 1'b1;
            acc_wr  = 1'b1;
            ptr_nxt = ptr_adv;
          end
          default: begin
            acc_load = 1'b1;
          end
        endcase
      end
    end
  end

  // Clearing pass after reset, then normal running.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_DELAY_FRAMES - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Memory write port is shared by the clearing pass and accepted requests.
  assign ram_we    = (state_r == ST_CLEAR) || (accept && acc_wr);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : ptr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : acc_wdata;

  sspd_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_DELAY_FRAMES)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      mode_r         <= sspd_pkg::MODE_NORMAL;
      delay_frames_r <= sspd_pkg::DELAY_FRAMES_RST;
      ptr_r          <= '0;
      parity_r       <= 1'b0;
      drain_cnt_r    <= '0;
      s1_v_r         <= 1'b0;
      s1_two_r       <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ptr_r       <= ptr_nxt;
      parity_r    <= parity_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sspd_pkg::CFG_MODE:  mode_r <= sspd_pkg::mode_t'(cfg_wdata[sspd_pkg::MODE_W-1:0]);
          sspd_pkg::CFG_DELAY: delay_frames_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        s1_v_r   <= acc_load;
        s1_two_r <= acc_two;
      end else if (s1_emit) begin
        s1_v_r   <= s1_two_r;
        s1_two_r <= 1'b0;
      end
      if (s1_emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Stage and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ram_r   <= acc_ram;
      s1_done_r  <= acc_done;
      s1_left_r  <= in_left;
      s1_right_r <= acc_right;
    end
    if (s1_emit) begin
      out_left_r  <= s1_ram_r ? ram_rdata : s1_left_r;
      out_right_r <= s1_right_r;
      out_last_r  <= !s1_two_r;
      out_done_r  <= s1_done_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

// ----- tb/tb_stereo_playback_speed_and_delay_unit.sv -----
// Testbench for the stereo playback speed and delay unit: directed and random traffic.
`timescale 1ns / 100ps

module tb_stereo_playback_speed_and_delay_unit;
  import sspd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT      = 20000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_CAP     = 50;

  // One frame as the codec should receive it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
    logic                done;
  } codec_frame_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;  // [15:0] left_sample, [31:16] right_sample
  logic                 in_tuser = 1'b0; // [0] opcode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;      // [15:0] left_out, [31:16] right_out
  logic                 out_tlast;
  logic                 out_tuser;      // [0] drain_done
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]   cfg_wdata = '0;

  // Our own copy of the block's state and registers.
  mode_t               mode_q = MODE_NORMAL;
  logic [DELAY_W-1:0]  delay_q = DELAY_FRAMES_RST;
  logic [SAMPLE_W-1:0] delay_mem [MAX_DELAY_FRAMES_DEF];
  int unsigned         ring_ptr = 0;
  logic                frame_odd = 1'b0;
  int unsigned         drain_cnt = 0;

  codec_frame_t pending_frames [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           hold_until = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;

  stereo_playback_speed_and_delay_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: the run must finish well within the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    out_tready <= (cycle_count >= hold_until) && ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Ring length as the block uses it: zero counts as one, large values saturate.
  function automatic int unsigned ring_length();
    int unsigned len;
    len = delay_q;
    if (len == 0) len = 1;
    if (len > MAX_DELAY_FRAMES_DEF) len = MAX_DELAY_FRAMES_DEF;
    return len;
  endfunction

  // Work out the frames that one accepted request sends to the codec.
  task automatic predict_request(input logic op, input logic [SAMPLE_W-1:0] l,
                                 input logic [SAMPLE_W-1:0] r);
    int unsigned         len;
    logic [SAMPLE_W-1:0] held;
    logic                done;
    len = ring_length();
    if (op == OP_DRAIN) begin
      held = delay_mem[ring_ptr];
      delay_mem[ring_ptr] = '0;
      ring_ptr = (ring_ptr + 1 >= len) ? 0 : ring_ptr + 1;
      drain_cnt++;
      done = 1'b0;
      if (drain_cnt >= len) begin
        done = 1'b1;
        drain_cnt = 0;
      end
      pending_frames.push_back('{left: held, right: '0, last: 1'b1, done: done});
    end else begin
      drain_cnt = 0;
      case (mode_q)
        MODE_HALF: begin
          pending_frames.push_back('{left: l, right: r, last: 1'b0, done: 1'b0});
          pending_frames.push_back('{left: l, right: r, last: 1'b1, done: 1'b0});
        end
        MODE_DOUBLE: begin
          if (!frame_odd) pending_frames.push_back('{left: l, right: r, last: 1'b1, done: 1'b0});
          frame_odd = ~frame_odd;
        end
        MODE_DELAY: begin
          held = delay_mem[ring_ptr];
          delay_mem[ring_ptr] = l;
          ring_ptr = (ring_ptr + 1 >= len) ? 0 : ring_ptr + 1;
          pending_frames.push_back('{left: held, right: r, last: 1'b1, done: 1'b0});
        end
        default: begin
          pending_frames.push_back('{left: l, right: r, last: 1'b1, done: 1'b0});
        end
      endcase
    end
  endtask

  // Send one request; called at a falling edge, returns at a falling edge with valid left high.
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] l,
                           input logic [SAMPLE_W-1:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {r, l};
    do @(posedge clk); while (!in_tready);
    predict_request(op, l, r);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected frame has arrived and the pipe is quiet.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DELAY_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) mode_q = mode_t'(value[MODE_W-1:0]);
    else delay_q = value;
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Checker: every frame on the codec side against the oldest expectation.
  always @(posedge clk) begin : check_result
    codec_frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected frame %h", out_tdata));
      end else begin
        want = pending_frames.pop_front();
        if (out_tdata[15:0] !== want.left)
          report_mismatch($sformatf("left %h, want %h", out_tdata[15:0], want.left));
        if (out_tdata[31:16] !== want.right)
          report_mismatch($sformatf("right %h, want %h", out_tdata[31:16], want.right));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
        if (out_tuser !== want.done)
          report_mismatch($sformatf("drain done %b, want %b", out_tuser, want.done));
      end
    end
  end

  // Normal mode straight out of reset, with the sample extremes.
  task automatic test_normal_extremes();
    send_item(OP_FRAME, 16'h7FFF, 16'h8000);
    send_item(OP_FRAME, 16'h8000, 16'h7FFF);
  endtask

  task automatic test_half_speed();
    wait_until_drained();
    write_register(CFG_MODE, DELAY_W'(MODE_HALF));
    send_item(OP_FRAME, 16'hFFFF, 16'h0000);
    send_item(OP_FRAME, 16'h0001, 16'hFFFE);
  endtask

  // Every other frame is dropped; a drain step in between leaves the parity alone.
  task automatic test_double_speed();
    wait_until_drained();
    write_register(CFG_MODE, DELAY_W'(MODE_DOUBLE));
    send_item(OP_FRAME, 16'h1111, 16'h2222);
    send_item(OP_DRAIN, 16'hFFFF, 16'hFFFF);
    send_item(OP_FRAME, 16'h3333, 16'h4444);
    send_item(OP_FRAME, 16'h5555, 16'h6666);
  endtask

  // Delay line at the reset length, after shrinking under the pointer, at zero and saturated.
  task automatic test_delay_line();
    wait_until_drained();
    write_register(CFG_MODE, DELAY_W'(MODE_DELAY));
    send_item(OP_FRAME, 16'hA5A5, 16'h5A5A);
    wait_until_drained();
    write_register(CFG_DELAY, 17'd4);
    send_item(OP_FRAME, 16'h0102, 16'h0304);
    // The pointer now sits at entry 3, beyond the new length of two.
    wait_until_drained();
    write_register(CFG_DELAY, 17'd2);
    send_item(OP_FRAME, 16'h8001, 16'h7FFE);
    send_item(OP_FRAME, 16'hC000, 16'h4000);
    wait_until_drained();
    write_register(CFG_DELAY, '0);
    send_item(OP_FRAME, 16'h1234, 16'h4321);
    send_item(OP_FRAME, 16'hFEDC, 16'hCDEF);
    wait_until_drained();
    write_register(CFG_DELAY, '1);
    send_item(OP_FRAME, 16'h7FFF, 16'h8000);
  endtask

  // Drain circles on a short ring, a second circle of zeros, and a frame breaking a circle.
  task automatic test_drain();
    wait_until_drained();
    write_register(CFG_DELAY, 17'd2);
    send_item(OP_FRAME, 16'h0AAA, 16'h0BBB);
    send_item(OP_FRAME, 16'h0CCC, 16'h0DDD);
    send_item(OP_DRAIN, 16'h0000, 16'h0000);
    send_item(OP_DRAIN, 16'hFFFF, 16'hFFFF);
    send_item(OP_DRAIN, 16'h0000, 16'hFFFF);
    send_item(OP_FRAME, 16'h0EEE, 16'h0FFF);
    send_item(OP_DRAIN, 16'hFFFF, 16'h0000);
    send_item(OP_DRAIN, 16'h0000, 16'h0000);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    wait_until_drained();
    write_register(CFG_MODE, DELAY_W'(MODE_NORMAL));
    @(posedge clk);
    hold_until = cycle_count + HOLD_CYCLES;
    @(negedge clk);
    repeat (30) send_item(OP_FRAME, random_sample(), random_sample());
  endtask

  // Random segments, each with fresh register values and bursts of drain steps.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int n_items);
    int sent;
    int seg_end;
    int burst;
    sent = 0;
    idle_pct  <= sender_idle;
    stall_pct <= receiver_stall;
    while (sent < n_items) begin
      wait_until_drained();
      write_register(CFG_MODE, DELAY_W'($urandom_range(3)));
      case ($urandom_range(9))
        0:       write_register(CFG_DELAY, '0);
        1:       write_register(CFG_DELAY, DELAY_W'($urandom_range(400, 13)));
        2:       write_register(CFG_DELAY, DELAY_W'($urandom_range(131071, 65536)));
        default: write_register(CFG_DELAY, DELAY_W'($urandom_range(12, 1)));
      endcase
      seg_end = sent + $urandom_range(40, 15);
      while (sent < seg_end) begin
        if ($urandom_range(5) == 0) begin
          // Mostly full circles, sometimes one short or one over.
          burst = int'(ring_length()) + int'($urandom_range(2)) - 1;
          if (burst < 1) burst = 1;
          if (burst > 24) burst = 24;
          repeat (burst) begin
            send_item(OP_DRAIN, random_sample(), random_sample());
            sent++;
          end
        end else begin
          send_item(OP_FRAME, random_sample(), random_sample());
          sent++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_DELAY_FRAMES_DEF; i++) delay_mem[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_normal_extremes();
    test_half_speed();
    test_double_speed();
    test_delay_line();
    test_drain();
    test_backpressure();
    test_random_traffic(0, 0, 150);
    test_random_traffic(83, 0, 150);
    test_random_traffic(0, 83, 150);
    test_random_traffic(15, 15, 150);

    // Let the last frames out, within a bound.
    in_tvalid <= 1'b0;
    for (int n = 0; n < END_WAIT && pending_frames.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_frames.size() != 0)
      report_mismatch($sformatf("%0d frames never arrived", pending_frames.size()));

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- stereo_playback_speed_and_delay_unit.f -----
hw/rtl/sspd_pkg.sv
hw/rtl/sspd_ram.sv
hw/rtl/stereo_playback_speed_and_delay_unit.sv
tb/tb_stereo_playback_speed_and_delay_unit.sv
